>>> rtl/core/u2rd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package u2rd_pkg;

   localparam int VALUE_W    = 64;
   localparam int RADIX_W    = 5;
   localparam int DIGIT_W    = 4;
   localparam int CHAR_W     = 8;
   localparam int MAX_DIGITS = 64;
   localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);
   localparam int STORE_AW   = $clog2(MAX_DIGITS);
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int CSR_AW     = 5;
   localparam int CSR_DW     = 64;

   localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
   localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(16);

   // register index, taken from paddr[4:3]
   localparam logic [1:0] REG_RADIX   = 2'd0;
   localparam logic [1:0] REG_ALPHA_LO = 2'd1;
   localparam logic [1:0] REG_ALPHA_HI = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [RADIX_W-1:0] radix;
      logic               error;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // alphabet character for one digit
   function automatic logic [CHAR_W-1:0] symbol_of(input logic [63:0] alpha_lo,
                                                    input logic [63:0] alpha_hi,
                                                    input logic [DIGIT_W-1:0] digit);
      logic [63:0] word;
      begin
         word = digit[3] ? alpha_hi : alpha_lo;
         symbol_of = word[{digit[2:0], 3'b000} +: CHAR_W];
      end
   endfunction

endpackage

`default_nettype wire

>>> rtl/core/u2rd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module u2rd_front import u2rd_pkg::*; (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [VALUE_W-1:0]  req_value,
   input  wire logic                psel,
   input  wire logic                penable,
   input  wire logic                pwrite,
   input  wire logic [CSR_AW-1:0]   paddr,
   input  wire logic [CSR_DW-1:0]   pwdata,
   output logic [CSR_DW-1:0]        prdata,
   output logic                     pready,
   input  wire queue_status_type    q_status,
   output logic                     push,
   output item_type                 push_item,
   output logic [63:0]              alpha_lo,
   output logic [63:0]              alpha_hi
);

   logic [RADIX_W-1:0] radix_ff;
   logic [63:0]        alpha_lo_ff;
   logic [63:0]        alpha_hi_ff;
   logic               wr_en;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[4:3];

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= '0;
         alpha_lo_ff <= '0;
         alpha_hi_ff <= '0;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_RADIX:    radix_ff    <= pwdata[RADIX_W-1:0];
            REG_ALPHA_LO: alpha_lo_ff <= pwdata;
            REG_ALPHA_HI: alpha_hi_ff <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_RADIX:    prdata = {{(CSR_DW-RADIX_W){1'b0}}, radix_ff};
         REG_ALPHA_LO: prdata = alpha_lo_ff;
         REG_ALPHA_HI: prdata = alpha_hi_ff;
         default:      prdata = '0;
      endcase
   end

   // classify: bad radix is flagged, large radix saturates
   always_comb begin
      push_item.value = req_value;
      push_item.error = (radix_ff < MIN_RADIX);
      push_item.radix = (radix_ff > MAX_RADIX) ? MAX_RADIX : radix_ff;
   end

   assign busy     = q_status.full;
   assign push     = start & ~q_status.full;
   assign alpha_lo = alpha_lo_ff;
   assign alpha_hi = alpha_hi_ff;

endmodule

`default_nettype wire

>>> rtl/core/u2rd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module u2rd_queue import u2rd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         push,
   input  wire item_type     push_item,
   input  wire logic         pop,
   output item_type          pop_item,
   output queue_status_type  q_status
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   item_type          entry_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              do_push, do_pop;

   assign q_status.full  = (count_ff == CW'(DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign do_push = push & ~q_status.full;
   assign do_pop  = pop & ~q_status.empty;
   assign pop_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/u2rd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module u2rd_back import u2rd_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire queue_status_type   q_status,
   input  wire item_type           pop_item,
   output logic                    pop,
   input  wire logic [63:0]        alpha_lo,
   input  wire logic [63:0]        alpha_hi,
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_digit_char,
   output logic                    rsp_last,
   output logic                    rsp_error
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EMIT
   } state_type;

   state_type            state_ff;
   logic [VALUE_W-1:0]   quot_ff;
   logic [RADIX_W-1:0]   rem_ff;
   logic [RADIX_W-1:0]   radix_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;
   logic [COUNT_W-1:0]   count_ff;
   logic [STORE_AW-1:0]  pos_ff;
   logic                 err_ff;

   logic [DIGIT_W-1:0]   store_mem [MAX_DIGITS];
   logic                 store_we;
   logic [DIGIT_W-1:0]   rd_data_ff;
   logic                 rd_valid_ff;
   logic                 rd_last_ff;

   logic                 rsp_valid_ff;
   logic [CHAR_W-1:0]    rsp_char_ff;
   logic                 rsp_last_ff;
   logic                 rsp_error_ff;

   logic [RADIX_W-1:0]   rem_shift;
   logic                 q_bit;
   logic [RADIX_W-1:0]   rem_in;
   logic [VALUE_W-1:0]   quot_in;
   logic [COUNT_W-1:0]   count_in;
   logic                 digit_done;

   // one restoring division step per cycle
   always_comb begin
      rem_shift  = {rem_ff[DIGIT_W-1:0], quot_ff[VALUE_W-1]};
      q_bit      = (rem_shift >= radix_ff);
      rem_in     = q_bit ? rem_shift - radix_ff : rem_shift;
      quot_in    = {quot_ff[VALUE_W-2:0], q_bit};
      count_in   = count_ff + COUNT_W'(1);
      digit_done = (bit_cnt_ff == BIT_CNT_W'(VALUE_W - 1));
   end

   assign pop      = (state_ff == ST_IDLE) & ~q_status.empty;
   assign store_we = (state_ff == ST_DIV) & digit_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         quot_ff    <= '0;
         rem_ff     <= '0;
         radix_ff   <= MAX_RADIX;
         bit_cnt_ff <= '0;
         count_ff   <= '0;
         pos_ff     <= '0;
         err_ff     <= 1'b0;
      end else begin
         err_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (pop) begin
                  if (pop_item.error) begin
                     err_ff <= 1'b1;
                  end else begin
                     quot_ff    <= pop_item.value;
                     radix_ff   <= pop_item.radix;
                     rem_ff     <= '0;
                     bit_cnt_ff <= '0;
                     count_ff   <= '0;
                     state_ff   <= ST_DIV;
                  end
               end
            end
            ST_DIV: begin
               quot_ff    <= quot_in;
               bit_cnt_ff <= bit_cnt_ff + BIT_CNT_W'(1);
               if (digit_done) begin
                  rem_ff   <= '0;
                  count_ff <= count_in;
                  if (quot_in == '0 || count_in >= COUNT_W'(MAX_DIGITS)) begin
                     pos_ff   <= count_ff[STORE_AW-1:0];
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  rem_ff <= rem_in;
               end
            end
            ST_EMIT: begin
               if (pos_ff == '0) begin
                  state_ff <= ST_IDLE;
               end else begin
                  pos_ff <= pos_ff - STORE_AW'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // digit store, no reset: every entry is written before it is emitted
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[count_ff[STORE_AW-1:0]] <= rem_in[DIGIT_W-1:0];
      end
      rd_data_ff <= store_mem[pos_ff];
      rd_last_ff <= (pos_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff  <= (state_ff == ST_EMIT);
         rsp_valid_ff <= rd_valid_ff | err_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_valid_ff) begin
         rsp_char_ff  <= symbol_of(alpha_lo, alpha_hi, rd_data_ff);
         rsp_last_ff  <= rd_last_ff;
         rsp_error_ff <= 1'b0;
      end else begin
         rsp_char_ff  <= '0;
         rsp_last_ff  <= 1'b1;
         rsp_error_ff <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_error_ff;

endmodule

`default_nettype wire

>>> rtl/core/unsigned_to_radix_digits_unit.sv
// flow: a value of n digits is taken from the queue when the sequencer is idle; the
//   bit-serial divider, one quotient bit per cycle, runs a full 64-bit division per
//   digit and stores the digits least significant first; the store is then read out
//   most significant first through the store read and output registers, one character
//   per cycle; the next item leaves the queue only once the last digit is read out
// a bad-radix item gives its single error result via the error flag and output registers
// reset is synchronous, active high; clears registers, queue and sequencer
`timescale 1ns / 1ps
`default_nettype none

module unsigned_to_radix_digits_unit import u2rd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // item input, taken when start is high and busy is low
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [VALUE_W-1:0] req_value,
   // character output, one strobe per character, no backpressure
   output logic                    rsp_valid,
   output logic [CHAR_W-1:0]       rsp_digit_char,
   output logic                    rsp_last,
   output logic                    rsp_error,
   // register port: radix at 0x00, alphabet low at 0x08, alphabet high at 0x10
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [CSR_AW-1:0]  paddr,
   input  wire logic [CSR_DW-1:0]  pwdata,
   output logic [CSR_DW-1:0]       prdata,
   output logic                    pready
);

   queue_status_type q_status;
   item_type         push_item;
   item_type         pop_item;
   logic             push;
   logic             pop;
   logic [63:0]      alpha_lo;
   logic [63:0]      alpha_hi;

   // front end: registers, radix check and saturation, acceptance
   u2rd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_value (req_value),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item),
      .alpha_lo  (alpha_lo),
      .alpha_hi  (alpha_hi)
   );

   // short queue so a new item can wait while the divider works
   u2rd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .q_status  (q_status)
   );

   // back end: serial divider, digit store, most-significant-first readout
   u2rd_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_item       (pop_item),
      .pop            (pop),
      .alpha_lo       (alpha_lo),
      .alpha_hi       (alpha_hi),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

endmodule

`default_nettype wire

>>> rtl/core/u2rd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module u2rd_checker import u2rd_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic [CHAR_W-1:0] rsp_digit_char,
   input wire logic              rsp_last,
   input wire logic              rsp_error
);

   // an error result stands alone
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> rsp_last && rsp_digit_char == '0)
      else $error("error result not single or not zero");

   // characters of one value come on consecutive cycles
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && !rsp_error)
      else $error("gap or error inside a digit string");

   // a non-final character is never an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> !rsp_error)
      else $error("error on non-final character");

   // no result right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe after reset");

endmodule

bind unsigned_to_radix_digits_unit u2rd_checker u_u2rd_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_digit_char (rsp_digit_char),
   .rsp_last       (rsp_last),
   .rsp_error      (rsp_error)
);

`default_nettype wire

>>> test/tb_unsigned_to_radix_digits_unit.sv
`timescale 1ns / 1ps

module tb_unsigned_to_radix_digits_unit;
   import u2rd_pkg::*;

   // one emitted character as the checker sees it
   typedef struct {
      logic [CHAR_W-1:0] ch;
      logic              last;
      logic              err;
   } char_result_type;

   // directed probe: register setting, value, and an optional hand-typed
   // single-character answer (error items, one-digit values)
   typedef struct {
      logic [RADIX_W-1:0] radix;
      logic [63:0]        alpha_lo;
      logic [63:0]        alpha_hi;
      logic [VALUE_W-1:0] value;
      logic               typed;
      logic [CHAR_W-1:0]  ch;
      logic               err;
   } probe_row_type;

   localparam int NUM_PROBES     = 20;
   localparam int RANDOM_ITEMS   = 120;
   localparam int MISMATCH_SHOWN = 10;
   // longest quiet stretch: conversion of 64 binary digits, plus a sender gap
   localparam int QUIET_LIMIT    = 20000;

   // ascii digits, digit i in byte i
   localparam logic [63:0] DEC_LO   = "76543210";
   localparam logic [63:0] DEC_HI   = "FEDCBA98";
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   logic clock = 1'b0;
   logic reset;
   logic start;
   logic busy;
   logic [VALUE_W-1:0] req_value;
   logic rsp_valid;
   logic [CHAR_W-1:0] rsp_digit_char;
   logic rsp_last;
   logic rsp_error;
   logic psel;
   logic penable;
   logic pwrite;
   logic [CSR_AW-1:0] paddr;
   logic [CSR_DW-1:0] pwdata;
   logic [CSR_DW-1:0] prdata;
   logic pready;

   // shadow of the register file, updated at the write edge
   logic [RADIX_W-1:0] cfg_radix = '0;
   logic [63:0]        cfg_alpha_lo = '0;
   logic [63:0]        cfg_alpha_hi = '0;

   // predictor's own copy of the conversion state
   logic [DIGIT_W-1:0] digit_mem [MAX_DIGITS];
   logic [6:0]         digit_total = '0;
   logic [63:0]        quotient_reg = '0;

   char_result_type pending_chars[$];
   int  mismatch_count = 0;
   int  quiet_cycles = 0;
   bit  gaps_on = 1'b1;

   probe_row_type probes [NUM_PROBES] = '{
      // reset setting and radix one: a radix below two flags an error
      '{5'd0,  64'h0,  64'h0,  64'h0,                  1'b1, 8'h00, 1'b1},
      '{5'd0,  64'h0,  64'h0,  ALL_ONES,               1'b1, 8'h00, 1'b1},
      '{5'd1,  64'h0,  64'h0,  64'd5,                  1'b1, 8'h00, 1'b1},
      // decimal, zero gives one digit
      '{5'd10, DEC_LO, DEC_HI, 64'h0,                  1'b1, "0",   1'b0},
      '{5'd10, DEC_LO, DEC_HI, 64'd9,                  1'b1, "9",   1'b0},
      '{5'd10, DEC_LO, DEC_HI, 64'd10,                 1'b0, 8'h00, 1'b0},
      '{5'd10, DEC_LO, DEC_HI, ALL_ONES,               1'b0, 8'h00, 1'b0},
      // binary, up to the full 64 digits
      '{5'd2,  DEC_LO, DEC_HI, 64'h0,                  1'b1, "0",   1'b0},
      '{5'd2,  DEC_LO, DEC_HI, 64'h1,                  1'b1, "1",   1'b0},
      '{5'd2,  DEC_LO, DEC_HI, 64'h8000_0000_0000_0000, 1'b0, 8'h00, 1'b0},
      '{5'd2,  DEC_LO, DEC_HI, ALL_ONES,               1'b0, 8'h00, 1'b0},
      // hex, every symbol
      '{5'd16, DEC_LO, DEC_HI, 64'd15,                 1'b1, "F",   1'b0},
      '{5'd16, DEC_LO, DEC_HI, 64'h0123_4567_89AB_CDEF, 1'b0, 8'h00, 1'b0},
      '{5'd16, DEC_LO, DEC_HI, ALL_ONES,               1'b0, 8'h00, 1'b0},
      // radix above sixteen saturates
      '{5'd17, DEC_LO, DEC_HI, 64'hFF,                 1'b0, 8'h00, 1'b0},
      '{5'd31, DEC_LO, DEC_HI, 64'hDEAD_BEEF_0BAD_F00D, 1'b0, 8'h00, 1'b0},
      // zero byte in the alphabet comes out like any other, then radix three and a custom alphabet
      '{5'd8,  64'h0706_0504_0302_0100, ALL_ONES, 64'h0, 1'b1, 8'h00, 1'b0},
      '{5'd8,  64'h0706_0504_0302_0100, ALL_ONES, 64'd511, 1'b0, 8'h00, 1'b0},
      '{5'd3,  DEC_LO, DEC_HI, ALL_ONES,               1'b0, 8'h00, 1'b0},
      '{5'd16, 64'h5555_5555_AAAA_AAAA, 64'hAAAA_5555_0000_FFFF,
       64'hFEDC_BA98_7654_3210, 1'b0, 8'h00, 1'b0}
   };

   unsigned_to_radix_digits_unit dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always #1 clock = ~clock;

   // alphabet lookup: upper half of the digits lives in the high register
   function automatic logic [CHAR_W-1:0] char_of_digit(input logic [DIGIT_W-1:0] d);
      logic [63:0] word;
      word = d[3] ? cfg_alpha_hi : cfg_alpha_lo;
      return CHAR_W'(word >> (8 * d[2:0]));
   endfunction

   // repeated division by the radix, digits kept least significant first,
   // then queued most significant first; keep=0 only updates the state
   function automatic void convert_value(input logic [VALUE_W-1:0] value, input bit keep);
      logic [RADIX_W-1:0] r_eff;
      int pos;
      if (cfg_radix < MIN_RADIX) begin
         // bad radix: one error character, state untouched
         if (keep) pending_chars.push_back('{ch: '0, last: 1'b1, err: 1'b1});
         return;
      end
      r_eff = (cfg_radix > MAX_RADIX) ? MAX_RADIX : cfg_radix;
      quotient_reg = value;
      digit_total = '0;
      do begin
         digit_mem[digit_total[5:0]] = DIGIT_W'(quotient_reg % 64'(r_eff));
         quotient_reg = quotient_reg / 64'(r_eff);
         digit_total++;
      end while (quotient_reg != 0 && digit_total < MAX_DIGITS);
      if (keep) begin
         for (int k = 0; k < digit_total; k++) begin
            pos = digit_total - 1 - k;
            pending_chars.push_back('{ch: char_of_digit(digit_mem[pos]),
                                      last: (k + 1 == digit_total), err: 1'b0});
         end
      end
   endfunction

   // random shifts spread the widths so that full-width values do not dominate the run
   function automatic logic [VALUE_W-1:0] random_value();
      logic [63:0] raw;
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 19))
         0: return '0;
         1: return ALL_ONES;
         2: return 64'h1 << $urandom_range(0, 63);
         default: return raw >> $urandom_range(0, 63);
      endcase
   endfunction

   function automatic void note_mismatch(input string what, input char_result_type want);
      mismatch_count++;
      if (mismatch_count <= MISMATCH_SHOWN)
         $display("%0t %s: expected char %h last %b error %b, got char %h last %b error %b",
                  $time, what, want.ch, want.last, want.err,
                  rsp_digit_char, rsp_last, rsp_error);
   endfunction

   // apb write, setup then access phase, register taken at the access edge
   task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_RADIX:    cfg_radix    = data[RADIX_W-1:0];
         REG_ALPHA_LO: cfg_alpha_lo = data;
         REG_ALPHA_HI: cfg_alpha_hi = data;
         default: ;
      endcase
   endtask

   // every item yields at least one character, so an empty queue means idle
   task automatic wait_drained();
      start <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
   endtask

   task automatic apply_config(input logic [RADIX_W-1:0] r, input logic [63:0] lo,
                               input logic [63:0] hi);
      wait_drained();
      write_reg(REG_RADIX, 64'(r));
      write_reg(REG_ALPHA_LO, lo);
      write_reg(REG_ALPHA_HI, hi);
   endtask

   // hold start until busy is low at an edge; start stays high on return
   // so back-to-back items need no second assignment in the same step
   task automatic send_value(input logic [VALUE_W-1:0] v);
      if (gaps_on && $urandom_range(0, 99) < 9) begin
         start     <= 1'b0;
         req_value <= {$urandom, $urandom};
         repeat ($urandom_range(1, 120)) @(posedge clock);
      end
      start     <= 1'b1;
      req_value <= v;
      do @(posedge clock); while (busy);
   endtask

   // result side: one strobe per character, no backpressure
   always @(posedge clock) begin : char_check
      char_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_chars.size() == 0) begin
            want = '{ch: '0, last: 1'b0, err: 1'b0};
            note_mismatch("unexpected character", want);
         end else begin
            want = pending_chars.pop_front();
            if (rsp_digit_char !== want.ch || rsp_last !== want.last ||
                rsp_error !== want.err)
               note_mismatch("character mismatch", want);
         end
      end
   end

   // quiet-cycle counter for the watchdog: any handshake restarts it
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      while (quiet_cycles < QUIET_LIMIT) @(posedge clock);
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      int done;
      int phase_len;
      logic [RADIX_W-1:0] r;
      logic [63:0] lo;
      logic [63:0] hi;
      logic [VALUE_W-1:0] v;

      reset     <= 1'b1;
      start     <= 1'b0;
      req_value <= '0;
      psel      <= 1'b0;
      penable   <= 1'b0;
      pwrite    <= 1'b0;
      paddr     <= '0;
      pwdata    <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed probes, register file rewritten only when the row asks
      foreach (probes[i]) begin
         if (probes[i].radix != cfg_radix || probes[i].alpha_lo != cfg_alpha_lo ||
             probes[i].alpha_hi != cfg_alpha_hi)
            apply_config(probes[i].radix, probes[i].alpha_lo, probes[i].alpha_hi);
         send_value(probes[i].value);
         convert_value(probes[i].value, !probes[i].typed);
         if (probes[i].typed)
            pending_chars.push_back('{ch: probes[i].ch, last: 1'b1, err: probes[i].err});
      end

      // random phases, each with a fresh register setting
      done = 0;
      while (done < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: r = 5'd0;
            1: r = 5'd1;
            2: r = MIN_RADIX;
            3: r = MAX_RADIX;
            4: r = RADIX_W'($urandom_range(17, 31));
            default: r = RADIX_W'($urandom_range(2, 16));
         endcase
         if ($urandom_range(0, 2) == 0) begin
            lo = DEC_LO;
            hi = DEC_HI;
         end else begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end
         apply_config(r, lo, hi);
         phase_len = $urandom_range(6, 24);
         for (int j = 0; j < phase_len && done < RANDOM_ITEMS; j++) begin
            // a stretch with the sender never pausing
            gaps_on = !(done >= 50 && done < 90);
            v = random_value();
            send_value(v);
            convert_value(v, 1'b1);
            done++;
         end
      end

      // let the last characters out, then watch for strays
      wait_drained();
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && pending_chars.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/u2rd_pkg.sv
rtl/core/u2rd_front.sv
rtl/core/u2rd_queue.sv
rtl/core/u2rd_back.sv
rtl/core/unsigned_to_radix_digits_unit.sv
rtl/core/u2rd_checker.sv
test/tb_unsigned_to_radix_digits_unit.sv
